[rtl/assert_macros.svh]
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the format specifier parser checker.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is high
`define FSP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define FSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fsp_pkg.sv]
// -----------------------------------------------------------------------------
// fsp_pkg
// Shared widths and conversion type codes for the format specifier parser.
// -----------------------------------------------------------------------------
package fsp_pkg;

  localparam int CH_W    = 8;
  localparam int ARG_W   = 32;
  localparam int FW_W    = 31;
  localparam int PREC_W  = 32;
  localparam int CONV_W  = 4;
  localparam int USED_W  = 2;

  localparam logic [FW_W-1:0] SAT_MAX = {FW_W{1'b1}};

  localparam logic [CONV_W-1:0] CONV_NONE = 4'd0;
  localparam logic [CONV_W-1:0] CONV_C    = 4'd1;
  localparam logic [CONV_W-1:0] CONV_S    = 4'd2;
  localparam logic [CONV_W-1:0] CONV_P    = 4'd3;
  localparam logic [CONV_W-1:0] CONV_D    = 4'd4;
  localparam logic [CONV_W-1:0] CONV_I    = 4'd5;
  localparam logic [CONV_W-1:0] CONV_U    = 4'd6;
  localparam logic [CONV_W-1:0] CONV_XL   = 4'd7;
  localparam logic [CONV_W-1:0] CONV_XU   = 4'd8;
  localparam logic [CONV_W-1:0] CONV_PCT  = 4'd9;

  localparam logic [USED_W-1:0] MAX_STARS = 2'd2;

endpackage

[rtl/format_spec_parser_top.sv]
// -----------------------------------------------------------------------------
// format_spec_parser_top - printf format specifier parser
// Timing: a closing character's result word is valid in the cycle after accept.
// Throughput: one character per cycle while not stalled; one x10 add per word.
// Reset: synchronous; parser returns to idle and the result register empties.
// -----------------------------------------------------------------------------
module format_spec_parser_top
  import fsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [CH_W-1:0]          ch,
  input  logic signed [ARG_W-1:0]  next_arg_first,
  input  logic signed [ARG_W-1:0]  next_arg_second,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     left_justify,
  output logic                     zero_pad,
  output logic [FW_W-1:0]          field_width,
  output logic signed [PREC_W-1:0] prec_value,
  output logic [CONV_W-1:0]        conv_type,
  output logic                     term_consumed,
  output logic [USED_W-1:0]        args_used
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_FLAGS   = 3'd1;
  localparam logic [2:0] PH_WDIGITS = 3'd2;
  localparam logic [2:0] PH_WSKIP   = 3'd3;
  localparam logic [2:0] PH_PSTART  = 3'd4;
  localparam logic [2:0] PH_PDIGITS = 3'd5;
  localparam logic [2:0] PH_PSKIP   = 3'd6;

  localparam logic [CH_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  function automatic logic [FW_W-1:0] acc_digit(input logic [FW_W-1:0] acc,
                                                 input logic [CH_W-1:0] c);
    logic [FW_W+3:0] n;
    n = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(FW_W){1'b0}}, c[3:0]};
    return (n > {4'b0000, SAT_MAX}) ? SAT_MAX : n[FW_W-1:0];
  endfunction

  function automatic logic [CONV_W-1:0] conv_code(input logic [CH_W-1:0] c);
    logic [CONV_W-1:0] t;
    case (c)
      8'h63:   t = CONV_C;
      8'h73:   t = CONV_S;
      8'h70:   t = CONV_P;
      8'h64:   t = CONV_D;
      8'h69:   t = CONV_I;
      8'h75:   t = CONV_U;
      8'h78:   t = CONV_XL;
      8'h58:   t = CONV_XU;
      CH_PCT:  t = CONV_PCT;
      default: t = CONV_NONE;
    endcase
    return t;
  endfunction

  logic [2:0]             phase, phase_next;
  logic                   minus_flag, minus_flag_next;
  logic                   zero_flag, zero_flag_next;
  logic [FW_W-1:0]        width_acc, width_acc_next;
  logic [PREC_W-1:0]      prec_acc, prec_acc_next;
  logic [USED_W-1:0]      stars_taken, stars_taken_next;

  logic                   emit;
  logic                   accept;
  logic                   is_digit;
  logic [ARG_W-1:0]       star_arg;
  logic [ARG_W-1:0]       star_neg;
  logic [FW_W-1:0]        star_width;
  logic [USED_W-1:0]      stars_inc;
  logic [CONV_W-1:0]      conv_code_now;

  assign is_digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign star_arg      = (stars_taken == '0) ? next_arg_first : next_arg_second;
  assign star_neg      = '0 - star_arg;
  assign star_width    = !star_arg[ARG_W-1] ? star_arg[FW_W-1:0] :
                         (star_neg[ARG_W-1] ? SAT_MAX : star_neg[FW_W-1:0]);
  assign stars_inc     = (stars_taken < MAX_STARS) ? stars_taken + 1'b1 : stars_taken;
  assign conv_code_now = conv_code(ch);

  always_comb begin
    phase_next       = phase;
    minus_flag_next  = minus_flag;
    zero_flag_next   = zero_flag;
    width_acc_next   = width_acc;
    prec_acc_next    = prec_acc;
    stars_taken_next = stars_taken;
    emit             = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (ch == CH_PCT) begin
          minus_flag_next  = 1'b0;
          zero_flag_next   = 1'b0;
          width_acc_next   = '0;
          prec_acc_next    = '1;
          stars_taken_next = '0;
          phase_next       = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        if (ch == CH_MINUS) begin
          minus_flag_next = 1'b1;
        end else if (ch == CH_ZERO) begin
          zero_flag_next = 1'b1;
        end else if (ch == CH_STAR) begin
          if (star_arg[ARG_W-1]) begin
            minus_flag_next = 1'b1;
          end
          width_acc_next   = star_width;
          stars_taken_next = stars_inc;
          phase_next       = PH_WSKIP;
        end else if (is_digit) begin
          width_acc_next = acc_digit('0, ch);
          phase_next     = PH_WDIGITS;
        end else if (ch == CH_DOT) begin
          prec_acc_next = '0;
          phase_next    = PH_PSTART;
        end else begin
          emit = 1'b1;
        end
      end
      PH_WDIGITS: begin
        if (is_digit) begin
          width_acc_next = acc_digit(width_acc, ch);
        end else if (ch == CH_STAR) begin
          phase_next = PH_WSKIP;
        end else if (ch == CH_DOT) begin
          prec_acc_next = '0;
          phase_next    = PH_PSTART;
        end else begin
          emit = 1'b1;
        end
      end
      PH_WSKIP: begin
        if (ch == CH_DOT) begin
          prec_acc_next = '0;
          phase_next    = PH_PSTART;
        end else if (!(is_digit || ch == CH_STAR)) begin
          emit = 1'b1;
        end
      end
      PH_PSTART: begin
        if (ch == CH_STAR) begin
          prec_acc_next    = star_arg;
          stars_taken_next = stars_inc;
          phase_next       = PH_PSKIP;
        end else if (is_digit) begin
          prec_acc_next = {1'b0, acc_digit('0, ch)};
          phase_next    = PH_PDIGITS;
        end else if (ch == CH_DOT) begin
          phase_next = PH_PSKIP;
        end else begin
          emit = 1'b1;
        end
      end
      PH_PDIGITS: begin
        if (is_digit) begin
          prec_acc_next = {1'b0, acc_digit(prec_acc[FW_W-1:0], ch)};
        end else if (ch == CH_STAR || ch == CH_DOT) begin
          phase_next = PH_PSKIP;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        if (!(is_digit || ch == CH_STAR || ch == CH_DOT)) begin
          emit = 1'b1;
        end
      end
    endcase
    if (emit) begin
      phase_next = PH_IDLE;
    end
  end

  // hold only words that close a specifier while the result register is blocked
  assign item_stall = result_valid && result_stall && emit;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      minus_flag  <= 1'b0;
      zero_flag   <= 1'b0;
      width_acc   <= '0;
      prec_acc    <= '1;
      stars_taken <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      minus_flag  <= minus_flag_next;
      zero_flag   <= zero_flag_next;
      width_acc   <= width_acc_next;
      prec_acc    <= prec_acc_next;
      stars_taken <= stars_taken_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      left_justify  <= minus_flag;
      zero_pad      <= zero_flag;
      field_width   <= width_acc;
      prec_value    <= prec_acc;
      conv_type     <= conv_code_now;
      term_consumed <= (conv_code_now != CONV_NONE);
      args_used     <= stars_taken;
    end
  end

endmodule

[rtl/fsp_checker.sv]
// -----------------------------------------------------------------------------
// fsp_port_checks
// Port-level checks on the format specifier parser result channel.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsp_port_checks
  import fsp_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     item_valid,
  input logic                     item_stall,
  input logic                     result_valid,
  input logic                     result_stall,
  input logic                     left_justify,
  input logic                     zero_pad,
  input logic [FW_W-1:0]          field_width,
  input logic signed [PREC_W-1:0] prec_value,
  input logic [CONV_W-1:0]        conv_type,
  input logic                     term_consumed,
  input logic [USED_W-1:0]        args_used
);

  logic                                 in_word;
  logic [FW_W+PREC_W+CONV_W+USED_W+2:0] res_word;

  assign in_word  = item_valid && !item_stall;
  assign res_word = {left_justify, zero_pad, field_width, prec_value, conv_type,
                     term_consumed, args_used};

  `FSP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result valid after reset")
  `FSP_ASSERT(a_hold_word, clk, rst, result_valid && result_stall |=> result_valid && $stable(res_word), "stalled result word changed")
  `FSP_ASSERT(a_consumed, clk, rst, result_valid |-> (term_consumed == (conv_type != CONV_NONE)) && (conv_type <= CONV_PCT), "conversion code and consumed flag disagree")
  `FSP_ASSERT(a_args, clk, rst, result_valid |-> args_used <= MAX_STARS, "too many star arguments")
  `FSP_ASSERT(a_new_word, clk, rst, !in_word && !result_stall |=> !result_valid, "result word without an accepted character")

endmodule

bind format_spec_parser_top fsp_port_checks u_fsp_port_checks (.*);

[tb/fsp_checker.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// fsp_checker
// Watches both channels of the format specifier parser. Every accepted
// character word runs through a local parser model; each closed specifier
// queues the expected result word, and every accepted result word is compared
// field by field against the oldest queued one.
// -----------------------------------------------------------------------------
module fsp_checker
  import fsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  logic                     item_stall,
  input  logic [CH_W-1:0]          ch,
  input  logic signed [ARG_W-1:0]  next_arg_first,
  input  logic signed [ARG_W-1:0]  next_arg_second,
  input  logic                     result_valid,
  input  logic                     result_stall,
  input  logic                     left_justify,
  input  logic                     zero_pad,
  input  logic [FW_W-1:0]          field_width,
  input  logic signed [PREC_W-1:0] prec_value,
  input  logic [CONV_W-1:0]        conv_type,
  input  logic                     term_consumed,
  input  logic [USED_W-1:0]        args_used,
  output int                       fail_count,
  output int                       pending,
  output int                       checked
);

  localparam logic [CH_W-1:0] CH_PCT   = "%";
  localparam logic [CH_W-1:0] CH_MINUS = "-";
  localparam logic [CH_W-1:0] CH_ZERO  = "0";
  localparam logic [CH_W-1:0] CH_STAR  = "*";
  localparam logic [CH_W-1:0] CH_DOT   = ".";
  localparam logic [CH_W-1:0] CH_C     = "c";
  localparam logic [CH_W-1:0] CH_S     = "s";
  localparam logic [CH_W-1:0] CH_P     = "p";
  localparam logic [CH_W-1:0] CH_D     = "d";
  localparam logic [CH_W-1:0] CH_I     = "i";
  localparam logic [CH_W-1:0] CH_U     = "u";
  localparam logic [CH_W-1:0] CH_XL    = "x";
  localparam logic [CH_W-1:0] CH_XU    = "X";
  localparam logic [CH_W-1:0] DIGIT_LO = 8'd47;
  localparam logic [CH_W-1:0] DIGIT_HI = 8'd58;
  localparam logic [PREC_W-1:0] SAT_32 = {1'b0, SAT_MAX};

  typedef enum logic [2:0] {
    SP_IDLE, SP_FLAGS, SP_WDIGITS, SP_WSKIP, SP_PSTART, SP_PDIGITS, SP_PSKIP
  } spec_phase_t;

  typedef struct packed {
    logic               left;
    logic               zero;
    logic [FW_W-1:0]    width;
    logic [PREC_W-1:0]  prec;
    logic [CONV_W-1:0]  conv;
    logic               consumed;
    logic [USED_W-1:0]  used;
  } spec_word_t;

  spec_phase_t       sp_phase;
  logic              sp_minus;
  logic              sp_zero;
  logic [FW_W-1:0]   sp_width;
  logic [PREC_W-1:0] sp_prec;
  logic [USED_W-1:0] sp_stars;

  spec_word_t spec_q[$];
  spec_word_t want;
  int         err_total = 0;
  int         n_checked = 0;

  function automatic logic is_digit(logic [CH_W-1:0] c);
    return (c > DIGIT_LO) && (c < DIGIT_HI);
  endfunction

  function automatic logic [PREC_W-1:0] sat_digit(logic [PREC_W-1:0] acc, logic [CH_W-1:0] c);
    logic [63:0] n;
    n = {32'd0, acc} * 64'd10 + {56'd0, c - CH_ZERO};
    return (n > {32'd0, SAT_32}) ? SAT_32 : n[PREC_W-1:0];
  endfunction

  function automatic logic [CONV_W-1:0] conv_of(logic [CH_W-1:0] c);
    case (c)
      CH_C:    return CONV_C;
      CH_S:    return CONV_S;
      CH_P:    return CONV_P;
      CH_D:    return CONV_D;
      CH_I:    return CONV_I;
      CH_U:    return CONV_U;
      CH_XL:   return CONV_XL;
      CH_XU:   return CONV_XU;
      CH_PCT:  return CONV_PCT;
      default: return CONV_NONE;
    endcase
  endfunction

  function automatic logic [ARG_W-1:0] take_arg(logic [ARG_W-1:0] a1, logic [ARG_W-1:0] a2);
    logic [ARG_W-1:0] v;
    v = (sp_stars == '0) ? a1 : a2;
    if (sp_stars < MAX_STARS) sp_stars = sp_stars + 1'b1;
    return v;
  endfunction

  task automatic parse_char(input logic [CH_W-1:0] c, input logic [ARG_W-1:0] a1,
                            input logic [ARG_W-1:0] a2);
    logic             closes;
    logic [ARG_W-1:0] v;
    spec_word_t       w;
    closes = 1'b0;
    case (sp_phase)
      SP_IDLE: if (c == CH_PCT) begin
        sp_minus = 1'b0;
        sp_zero  = 1'b0;
        sp_width = '0;
        sp_prec  = '1;
        sp_stars = '0;
        sp_phase = SP_FLAGS;
      end
      SP_FLAGS: begin
        if (c == CH_MINUS) sp_minus = 1'b1;
        else if (c == CH_ZERO) sp_zero = 1'b1;
        else if (c == CH_STAR) begin
          v = take_arg(a1, a2);
          if (v[ARG_W-1]) begin
            sp_minus = 1'b1;
            v = -v;
            if (v > SAT_32) v = SAT_32;
          end
          sp_width = v[FW_W-1:0];
          sp_phase = SP_WSKIP;
        end else if (is_digit(c)) begin
          v = sat_digit('0, c);
          sp_width = v[FW_W-1:0];
          sp_phase = SP_WDIGITS;
        end else if (c == CH_DOT) begin
          sp_prec  = '0;
          sp_phase = SP_PSTART;
        end else closes = 1'b1;
      end
      SP_WDIGITS: begin
        if (is_digit(c)) begin
          v = sat_digit({1'b0, sp_width}, c);
          sp_width = v[FW_W-1:0];
        end else if (c == CH_STAR) sp_phase = SP_WSKIP;
        else if (c == CH_DOT) begin
          sp_prec  = '0;
          sp_phase = SP_PSTART;
        end else closes = 1'b1;
      end
      SP_WSKIP: begin
        if (c == CH_DOT) begin
          sp_prec  = '0;
          sp_phase = SP_PSTART;
        end else if (!is_digit(c) && c != CH_STAR) closes = 1'b1;
      end
      SP_PSTART: begin
        if (c == CH_STAR) begin
          sp_prec  = take_arg(a1, a2);
          sp_phase = SP_PSKIP;
        end else if (is_digit(c)) begin
          sp_prec  = sat_digit('0, c);
          sp_phase = SP_PDIGITS;
        end else if (c == CH_DOT) sp_phase = SP_PSKIP;
        else closes = 1'b1;
      end
      SP_PDIGITS: begin
        if (is_digit(c)) sp_prec = sat_digit(sp_prec, c);
        else if (c == CH_STAR || c == CH_DOT) sp_phase = SP_PSKIP;
        else closes = 1'b1;
      end
      default: begin
        if (!is_digit(c) && c != CH_STAR && c != CH_DOT) closes = 1'b1;
      end
    endcase
    if (closes) begin
      w.left     = sp_minus;
      w.zero     = sp_zero;
      w.width    = sp_width;
      w.prec     = sp_prec;
      w.conv     = conv_of(c);
      w.consumed = (w.conv != CONV_NONE);
      w.used     = sp_stars;
      spec_q.push_back(w);
      sp_phase = SP_IDLE;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t chk: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
      err_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sp_phase = SP_IDLE;
      sp_minus = 1'b0;
      sp_zero  = 1'b0;
      sp_width = '0;
      sp_prec  = '1;
      sp_stars = '0;
      spec_q.delete();
    end else begin
      if (item_valid && !item_stall) parse_char(ch, next_arg_first, next_arg_second);
      if (result_valid && !result_stall) begin
        if (spec_q.size() == 0) begin
          $display("%0t chk: result word with none expected, expected none actual %h",
                   $time, {left_justify, zero_pad, field_width, prec_value, conv_type,
                           term_consumed, args_used});
          err_total++;
        end else begin
          want = spec_q.pop_front();
          check_field("left_justify", 32'(want.left), 32'(left_justify));
          check_field("zero_pad", 32'(want.zero), 32'(zero_pad));
          check_field("field_width", 32'(want.width), 32'(field_width));
          check_field("prec_value", want.prec, prec_value);
          check_field("conv_type", 32'(want.conv), 32'(conv_type));
          check_field("term_consumed", 32'(want.consumed), 32'(term_consumed));
          check_field("args_used", 32'(want.used), 32'(args_used));
          n_checked++;
        end
      end
    end
    fail_count <= err_total;
    pending    <= spec_q.size();
    checked    <= n_checked;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb - format specifier parser testbench
// Drives a directed character stream, then mostly well-formed random
// specifiers mixed with plain text and noise, with random idle bursts on
// both channels and one long result hold-off that backs up the input side.
// -----------------------------------------------------------------------------
module tb;
  import fsp_pkg::*;

  localparam int ITEM_TARGET    = 1550;
  localparam int CALM_TAIL      = 150;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [CH_W-1:0]  c;
    logic [ARG_W-1:0] a;
    logic [ARG_W-1:0] b;
  } char_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     item_valid = 1'b0;
  logic                     item_stall;
  logic [CH_W-1:0]          ch = '0;
  logic signed [ARG_W-1:0]  next_arg_first = '0;
  logic signed [ARG_W-1:0]  next_arg_second = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic                     left_justify;
  logic                     zero_pad;
  logic [FW_W-1:0]          field_width;
  logic signed [PREC_W-1:0] prec_value;
  logic [CONV_W-1:0]        conv_type;
  logic                     term_consumed;
  logic [USED_W-1:0]        args_used;

  int fail_count;
  int pending;
  int checked;

  char_word_t char_q[$];
  int         stim_len = 0;
  int         n_load = 0;
  int         n_acc = 0;
  int         gap_left = 0;
  int         burst_left = 0;
  int         hold_left = 0;
  bit         held_once = 1'b0;
  int         backpressure = 0;
  int         quiet_cycles = 0;
  bit         calm;
  bit         idle_phase;

  assign calm       = (n_load >= stim_len - CALM_TAIL);
  assign idle_phase = ((n_load / 128) % 2) == 0;

  always #2 clk = ~clk;

  format_spec_parser_top DUT (
    .clk, .rst, .item_valid, .item_stall, .ch, .next_arg_first, .next_arg_second,
    .result_valid, .result_stall, .left_justify, .zero_pad, .field_width, .prec_value,
    .conv_type, .term_consumed, .args_used
  );

  fsp_checker chk (
    .clk, .rst, .item_valid, .item_stall, .ch, .next_arg_first, .next_arg_second,
    .result_valid, .result_stall, .left_justify, .zero_pad, .field_width, .prec_value,
    .conv_type, .term_consumed, .args_used, .fail_count, .pending, .checked
  );

  function automatic logic [ARG_W-1:0] pick_arg();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'd0;
      4:       return $urandom_range(0, 99);
      5:       return -$urandom_range(1, 99);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input logic [CH_W-1:0] c, input logic [ARG_W-1:0] a,
                           input logic [ARG_W-1:0] b);
    char_word_t w;
    w.c = c;
    w.a = a;
    w.b = b;
    char_q.push_back(w);
  endtask

  task automatic push_ch(input logic [CH_W-1:0] c);
    push_item(c, pick_arg(), pick_arg());
  endtask

  task automatic push_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_ch(s[i]);
  endtask

  task automatic push_digits();
    int n;
    int i;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
    for (i = 0; i < n; i++) push_ch(CH_W'("0" + $urandom_range(0, 9)));
  endtask

  task automatic push_skip();
    int n;
    int i;
    n = $urandom_range(0, 2);
    for (i = 0; i < n; i++)
      case ($urandom_range(0, 2))
        0:       push_ch("*");
        1:       push_ch(".");
        default: push_ch(CH_W'("0" + $urandom_range(0, 9)));
      endcase
  endtask

  task automatic push_spec();
    string      letters;
    logic [7:0] c;
    int         n;
    int         i;
    letters = "cspdiuxX%";
    n = $urandom_range(0, 2);
    for (i = 0; i < n; i++) begin
      c = CH_W'($urandom_range(0, 255));
      push_ch((c == "%") ? 8'h61 : c);
    end
    push_ch("%");
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) push_ch($urandom_range(0, 1) ? "-" : "0");
    case ($urandom_range(0, 3))
      0: ;
      1: push_ch("*");
      default: push_digits();
    endcase
    if ($urandom_range(0, 3) == 0) push_skip();
    if ($urandom_range(0, 2) != 0) begin
      push_ch(".");
      case ($urandom_range(0, 5))
        0: ;
        1: push_ch("-");
        2: push_ch("*");
        default: push_digits();
      endcase
    end
    if ($urandom_range(0, 3) == 0) push_skip();
    if ($urandom_range(0, 3) != 0) push_ch(letters[$urandom_range(0, 8)]);
    else push_ch(CH_W'($urandom_range(0, 255)));
  endtask

  task automatic build_stream();
    int n;
    int i;
    push_str("ab");
    push_str("%-0");
    push_item("*", 32'h8000_0000, 32'h7FFF_FFFF);
    push_ch(".");
    push_item("*", 32'h0000_1234, 32'h7FFF_FFFF);
    push_ch("d");
    push_str("%.-");
    push_str("%99999999999x");
    while (char_q.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 6) != 0) push_spec();
      else begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
          push_ch(($urandom_range(0, 3) == 0) ? "%" : CH_W'($urandom_range(0, 255)));
      end
    end
    push_ch("d");
  endtask

  // sender: hold a stalled word, otherwise advance or idle
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (item_valid && !item_stall) n_acc <= n_acc + 1;
      if (item_valid && item_stall) backpressure <= backpressure + 1;
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (n_load < stim_len) begin
          if (!calm && idle_phase && hold_left == 0 && $urandom_range(0, 5) == 0) begin
            gap_left   <= $urandom_range(0, 2);
            item_valid <= 1'b0;
          end else begin
            ch              <= char_q[n_load].c;
            next_arg_first  <= char_q[n_load].a;
            next_arg_second <= char_q[n_load].b;
            item_valid      <= 1'b1;
            n_load          <= n_load + 1;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off mid run
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      burst_left   <= 0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (!held_once && n_load >= stim_len / 2) begin
      held_once    <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left   <= burst_left - 1;
      result_stall <= 1'b1;
    end else if (!calm && !idle_phase == ($urandom_range(0, 1) == 0)
                 && $urandom_range(0, 4) == 0) begin
      burst_left   <= $urandom_range(0, 2);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog, no word moved for %0d cycles, %0d results pending",
               quiet_cycles, pending);
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    build_stream();
    stim_len = char_q.size();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (n_acc == stim_len);
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d characters sent, %0d specifier results checked", stim_len, checked);
    $display("tb: input held off %0d cycles by back-pressure, incl. one long result hold",
             backpressure);
    if (fail_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
